// ----- src/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CA_ASSERT_IMPL(name, ante, cons, msg) \
  `CA_ASSERT(name, (ante) |-> (cons), msg)

`endif

// ----- src/ca3d_pkg.sv -----
// ----------------------------------------------------------------------------
// ca3d_pkg
// Widths, formats and shared types of the closest-approach pipeline.
// ----------------------------------------------------------------------------
package ca3d_pkg;

  localparam int COORD_W   = 24;             // Q16.8 inputs
  localparam int FRAC_BITS = 8;
  localparam int DIFF_W    = COORD_W + 1;    // p1-p2, v1-v2
  localparam int PROD_W    = 2 * DIFF_W;     // one product term
  localparam int SUM_W     = PROD_W + 2;     // dot products, unsigned magnitude
  localparam int NUM_W     = SUM_W + 1;      // signed numerator
  localparam int TIME_FRAC = 16;
  localparam int TIME_W    = 32;             // Q16.16
  localparam int DT_W      = DIFF_W + TIME_W; // dv*t
  localparam int D_W       = DT_W + 1;       // w*2^16 + dv*t
  localparam int LIM_W     = FRAC_BITS + 32; // component saturation point
  localparam int HALF_W    = LIM_W / 2;
  localparam int HI_W      = LIM_W - HALF_W;
  localparam int SQ_W      = 2 * LIM_W;
  localparam int ACC_W     = SQ_W + 2;
  localparam int DIST_SH   = 2 * FRAC_BITS + 16;
  localparam int S_W       = ACC_W - DIST_SH;
  localparam int DIST_W    = 48;
  localparam int EPS_W     = 32;
  localparam int ADDR_W    = 2;
  localparam int DATA_W    = 32;

  localparam logic [ADDR_W-1:0] ADDR_EPS = ADDR_W'(0);
  localparam logic [EPS_W-1:0]  EPS_RESET = EPS_W'(1);

  localparam logic [TIME_W-1:0] TIME_MAX_POS = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic [TIME_W-1:0] TIME_MAX_NEG = {1'b1, {(TIME_W-1){1'b0}}};

  // Per-item data that rides alongside the divider.
  typedef struct packed {
    logic                         neg;
    logic                         flag;
    logic                         ovf;
    logic [2:0][DIFF_W-1:0]       w;
    logic [2:0][DIFF_W-1:0]       dv;
  } side_t;

endpackage

// ----- src/ca3d_div.sv -----
// ----------------------------------------------------------------------------
// ca3d_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module ca3d_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [ca3d_pkg::SUM_W-1:0]   mag_i,
  input  logic [ca3d_pkg::SUM_W-1:0]   dd_i,
  input  ca3d_pkg::side_t              side_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [ca3d_pkg::TIME_W-1:0]  quo_o,
  output ca3d_pkg::side_t              side_o
);

  localparam int N = ca3d_pkg::TIME_W;
  localparam int SW = ca3d_pkg::SUM_W;
  localparam int SH = ca3d_pkg::TIME_W - ca3d_pkg::TIME_FRAC;

  logic                  v_s   [N+1];
  logic [SW-1:0]         rem_s [N+1];
  logic [N-1:0]          nb_s  [N+1];
  logic [N-1:0]          quo_s [N+1];
  logic [SW-1:0]         dd_s  [N+1];
  ca3d_pkg::side_t       side_s[N+1];
  logic                  adv   [N+1];

  // stage 0 inputs: high part of mag<<16 seeds the remainder
  assign v_s[0]    = valid_i;
  assign rem_s[0]  = mag_i >> SH;
  assign nb_s[0]   = {mag_i[ca3d_pkg::TIME_FRAC-1:0], {SH{1'b0}}};
  assign quo_s[0]  = '0;
  assign dd_s[0]   = dd_i;
  assign side_s[0] = side_i;
  assign adv[N]    = ready_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [SW:0] r2, diff;
    logic        ge;

    assign adv[k] = !v_s[k+1] || adv[k+1];
    assign r2     = {rem_s[k], nb_s[k][N-1]};
    assign diff   = r2 - {1'b0, dd_s[k]};
    assign ge     = r2 >= {1'b0, dd_s[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (adv[k]) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        rem_s[k+1]  <= ge ? diff[SW-1:0] : r2[SW-1:0];
        nb_s[k+1]   <= nb_s[k] << 1;
        quo_s[k+1]  <= {quo_s[k][N-2:0], ge};
        dd_s[k+1]   <= dd_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_s[N];
  assign quo_o   = quo_s[N];
  assign side_o  = side_s[N];

endmodule

// ----- src/closest_approach_3d.sv -----
// ----------------------------------------------------------------------------
// closest_approach_3d
// Time of closest approach of two points moving in 3D and squared distance
// at that time; fully pipelined, one pair per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  in       | in_valid_i/in_ready_o | first/second pos/vel x,y,z (Q16.8)
//  out      | out_valid_o/out_ready_i | approach_time, sq_distance, parallel
//  cfg      | APB psel/penable/...  | epsilon_sq_speed at byte address 0
//
//  Throughput is one transaction per cycle unless the output stalls; there are 4
//  front stages, 32 divider stages (one quotient bit each), 6 back stages.
//  Every stage has its own valid bit and advances when it is empty or its
//  successor advances, so bubbles are squeezed out under a stalled output.
//  rst_ni clears all valid bits and sets epsilon to 1; data regs not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module closest_approach_3d (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ca3d_pkg::COORD_W-1:0] first_pos_x_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] first_pos_y_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] first_pos_z_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] first_vel_x_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] first_vel_y_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] first_vel_z_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] second_pos_x_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] second_pos_y_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] second_pos_z_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] second_vel_x_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] second_vel_y_i,
  input  logic signed [ca3d_pkg::COORD_W-1:0] second_vel_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ca3d_pkg::TIME_W-1:0]  approach_time_o,
  output logic [ca3d_pkg::DIST_W-1:0]         approach_sq_distance_o,
  output logic                                parallel_motion_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ca3d_pkg::ADDR_W-1:0]         paddr,
  input  logic [ca3d_pkg::DATA_W-1:0]         pwdata,
  output logic [ca3d_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int DW = ca3d_pkg::DIFF_W;
  localparam int PW = ca3d_pkg::PROD_W;
  localparam int SW = ca3d_pkg::SUM_W;
  localparam int NW = ca3d_pkg::NUM_W;
  localparam int TW = ca3d_pkg::TIME_W;

  // ---------------- configuration ----------------
  logic [ca3d_pkg::EPS_W-1:0] eps_q;
  logic                       eps_wr;

  assign pready = 1'b1;
  assign eps_wr = psel && penable && pwrite && (paddr == ca3d_pkg::ADDR_EPS);
  assign prdata = (paddr == ca3d_pkg::ADDR_EPS) ? ca3d_pkg::DATA_W'(eps_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= ca3d_pkg::EPS_RESET;
    end else if (eps_wr) begin
      eps_q <= pwdata[ca3d_pkg::EPS_W-1:0];
    end
  end

  // ---------------- flow control ----------------
  // v1..v4 front, divider, v5..v10 back; v10 is the output register
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9, adv10;
  logic div_ready, div_valid;

  assign adv10 = !v10_q || out_ready_i;
  assign adv9  = !v9_q || adv10;
  assign adv8  = !v8_q || adv9;
  assign adv7  = !v7_q || adv8;
  assign adv6  = !v6_q || adv7;
  assign adv5  = !v5_q || adv6;
  assign adv4  = !v4_q || div_ready;
  assign adv3  = !v3_q || adv4;
  assign adv2  = !v2_q || adv3;
  assign adv1  = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0;
    end else begin
      if (adv1)  v1_q  <= in_valid_i;
      if (adv2)  v2_q  <= v1_q;
      if (adv3)  v3_q  <= v2_q;
      if (adv4)  v4_q  <= v3_q;
      if (adv5)  v5_q  <= div_valid;
      if (adv6)  v6_q  <= v5_q;
      if (adv7)  v7_q  <= v6_q;
      if (adv8)  v8_q  <= v7_q;
      if (adv9)  v9_q  <= v8_q;
      if (adv10) v10_q <= v9_q;
    end
  end

  // ---------------- S1: relative position and velocity ----------------
  logic signed [ca3d_pkg::COORD_W-1:0] p1 [3], p2 [3], u1 [3], u2 [3];
  logic signed [DW-1:0] w1_q [3], dv1_q [3];

  assign p1 = '{first_pos_x_i, first_pos_y_i, first_pos_z_i};
  assign p2 = '{second_pos_x_i, second_pos_y_i, second_pos_z_i};
  assign u1 = '{first_vel_x_i, first_vel_y_i, first_vel_z_i};
  assign u2 = '{second_vel_x_i, second_vel_y_i, second_vel_z_i};

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      for (int i = 0; i < 3; i++) begin
        w1_q[i]  <= DW'(p1[i]) - DW'(p2[i]);
        dv1_q[i] <= DW'(u1[i]) - DW'(u2[i]);
      end
    end
  end

  // ---------------- S2: per-axis products ----------------
  logic signed [PW-1:0] dd2_q [3], wd2_q [3];
  logic signed [DW-1:0] w2_q [3], dv2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      for (int i = 0; i < 3; i++) begin
        dd2_q[i] <= PW'(dv1_q[i]) * PW'(dv1_q[i]);
        wd2_q[i] <= PW'(w1_q[i]) * PW'(dv1_q[i]);
        w2_q[i]  <= w1_q[i];
        dv2_q[i] <= dv1_q[i];
      end
    end
  end

  // ---------------- S3: dot products, numerator negated ----------------
  logic [SW-1:0]        dd3_q;
  logic signed [NW-1:0] num3_q;
  logic signed [DW-1:0] w3_q [3], dv3_q [3];

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      dd3_q  <= SW'(dd2_q[0][PW-1:0]) + SW'(dd2_q[1][PW-1:0]) + SW'(dd2_q[2][PW-1:0]);
      num3_q <= -(NW'(wd2_q[0]) + NW'(wd2_q[1]) + NW'(wd2_q[2]));
      w3_q   <= w2_q;
      dv3_q  <= dv2_q;
    end
  end

  // ---------------- S4: slow-motion test, magnitude, overflow ----------------
  logic [SW-1:0]   mag4_q, dd4_q, mag3;
  ca3d_pkg::side_t side4_q;
  logic            neg3;

  assign neg3 = num3_q[NW-1];
  assign mag3 = neg3 ? SW'(-num3_q) : SW'(num3_q);

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      mag4_q       <= mag3;
      dd4_q        <= dd3_q;
      side4_q.neg  <= neg3;
      side4_q.flag <= (dd3_q == '0) || (dd3_q < SW'(eps_q));
      // quotient needs more than TIME_W bits
      side4_q.ovf  <= {ca3d_pkg::TIME_FRAC'(0), mag3} >= {dd3_q, ca3d_pkg::TIME_FRAC'(0)};
      for (int i = 0; i < 3; i++) begin
        side4_q.w[i]  <= w3_q[i];
        side4_q.dv[i] <= dv3_q[i];
      end
    end
  end

  // ---------------- divider: (mag << 16) / dd ----------------
  logic [TW-1:0]   quo;
  ca3d_pkg::side_t side_dv;

  ca3d_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .ready_o (div_ready),
    .mag_i   (mag4_q),
    .dd_i    (dd4_q),
    .side_i  (side4_q),
    .valid_o (div_valid),
    .ready_i (adv5),
    .quo_o   (quo),
    .side_o  (side_dv)
  );

  // ---------------- S5: saturate and sign the time ----------------
  logic [TW-1:0]        tmax, qsat;
  logic signed [TW-1:0] t5_q;
  logic                 flag5_q;
  logic signed [DW-1:0] w5_q [3], dv5_q [3];

  assign tmax = side_dv.neg ? ca3d_pkg::TIME_MAX_NEG : ca3d_pkg::TIME_MAX_POS;
  assign qsat = (side_dv.ovf || quo > tmax) ? tmax : quo;

  always_ff @(posedge clk_i) begin
    if (adv5) begin
      t5_q    <= side_dv.flag ? '0 : (side_dv.neg ? -qsat : qsat);
      flag5_q <= side_dv.flag;
      for (int i = 0; i < 3; i++) begin
        w5_q[i]  <= side_dv.w[i];
        dv5_q[i] <= side_dv.dv[i];
      end
    end
  end

  // ---------------- S6: dv * t ----------------
  logic signed [ca3d_pkg::DT_W-1:0] p6_q [3];
  logic signed [DW-1:0]             w6_q [3];
  logic signed [TW-1:0]             t6_q;
  logic                             flag6_q;

  always_ff @(posedge clk_i) begin
    if (adv6) begin
      for (int i = 0; i < 3; i++) begin
        p6_q[i] <= ca3d_pkg::DT_W'(dv5_q[i]) * ca3d_pkg::DT_W'(t5_q);
        w6_q[i] <= w5_q[i];
      end
      t6_q    <= t5_q;
      flag6_q <= flag5_q;
    end
  end

  // ---------------- S7: offset at closest approach, magnitude ----------------
  logic signed [ca3d_pkg::D_W-1:0] d7 [3];
  logic [ca3d_pkg::D_W-1:0]        a7 [3];
  logic [ca3d_pkg::LIM_W-1:0]      m7_q [3];
  logic [2:0]                      sat7_q;
  logic signed [TW-1:0]            t7_q;
  logic                            flag7_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d7[i] = (ca3d_pkg::D_W'(w6_q[i]) <<< ca3d_pkg::TIME_FRAC) + ca3d_pkg::D_W'(p6_q[i]);
      a7[i] = d7[i][ca3d_pkg::D_W-1] ? ca3d_pkg::D_W'(-d7[i]) : ca3d_pkg::D_W'(d7[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv7) begin
      for (int i = 0; i < 3; i++) begin
        m7_q[i]   <= a7[i][ca3d_pkg::LIM_W-1:0];
        sat7_q[i] <= |a7[i][ca3d_pkg::D_W-1:ca3d_pkg::LIM_W];
      end
      t7_q    <= t6_q;
      flag7_q <= flag6_q;
    end
  end

  // ---------------- S8: square, split in two partial products ----------------
  logic [ca3d_pkg::LIM_W+ca3d_pkg::HALF_W-1:0] pl8_q [3];
  logic [ca3d_pkg::LIM_W+ca3d_pkg::HI_W-1:0]   ph8_q [3];
  logic                                        sat8_q;
  logic signed [TW-1:0]                        t8_q;
  logic                                        flag8_q;

  always_ff @(posedge clk_i) begin
    if (adv8) begin
      for (int i = 0; i < 3; i++) begin
        pl8_q[i] <= (ca3d_pkg::LIM_W+ca3d_pkg::HALF_W)'(m7_q[i]) *
                    (ca3d_pkg::LIM_W+ca3d_pkg::HALF_W)'(m7_q[i][ca3d_pkg::HALF_W-1:0]);
        ph8_q[i] <= (ca3d_pkg::LIM_W+ca3d_pkg::HI_W)'(m7_q[i]) *
                    (ca3d_pkg::LIM_W+ca3d_pkg::HI_W)'(m7_q[i][ca3d_pkg::LIM_W-1:ca3d_pkg::HALF_W]);
      end
      sat8_q  <= |sat7_q;
      t8_q    <= t7_q;
      flag8_q <= flag7_q;
    end
  end

  // ---------------- S9: combine partial products ----------------
  logic [ca3d_pkg::SQ_W-1:0] sq9_q [3];
  logic                      sat9_q;
  logic signed [TW-1:0]      t9_q;
  logic                      flag9_q;

  always_ff @(posedge clk_i) begin
    if (adv9) begin
      for (int i = 0; i < 3; i++) begin
        sq9_q[i] <= ca3d_pkg::SQ_W'(pl8_q[i]) +
                    (ca3d_pkg::SQ_W'(ph8_q[i]) << ca3d_pkg::HALF_W);
      end
      sat9_q  <= sat8_q;
      t9_q    <= t8_q;
      flag9_q <= flag8_q;
    end
  end

  // ---------------- S10: sum, scale to Q32.16, saturate; output register ----
  logic [ca3d_pkg::ACC_W-1:0]  acc;
  logic [ca3d_pkg::S_W-1:0]    scaled;
  logic [ca3d_pkg::DIST_W-1:0] dist10_q;
  logic signed [TW-1:0]        t10_q;
  logic                        flag10_q;

  assign acc    = ca3d_pkg::ACC_W'(sq9_q[0]) + ca3d_pkg::ACC_W'(sq9_q[1]) +
                  ca3d_pkg::ACC_W'(sq9_q[2]);
  assign scaled = acc[ca3d_pkg::ACC_W-1:ca3d_pkg::DIST_SH];

  always_ff @(posedge clk_i) begin
    if (adv10) begin
      dist10_q <= (sat9_q || (|scaled[ca3d_pkg::S_W-1:ca3d_pkg::DIST_W])) ?
                  '1 : scaled[ca3d_pkg::DIST_W-1:0];
      t10_q    <= t9_q;
      flag10_q <= flag9_q;
    end
  end

  assign out_valid_o            = v10_q;
  assign approach_time_o        = t10_q;
  assign approach_sq_distance_o = dist10_q;
  assign parallel_motion_o      = flag10_q;

  // ---------------- assertions ----------------
  `CA_ASSERT_IMPL(a_parallel_time_zero, out_valid_o && parallel_motion_o,
    approach_time_o == '0, "parallel motion with nonzero time")
  `CA_ASSERT_IMPL(a_stall_only_when_full, !in_ready_o,
    out_valid_o && !out_ready_i, "input stalled while output not blocked")
  `CA_ASSERT(a_eps_write, eps_wr |=> eps_q == $past(pwdata[ca3d_pkg::EPS_W-1:0]), "epsilon write lost")

endmodule
